// File: rtl/s2rc_pkg.sv
package s2rc_pkg;

    // Field widths
    localparam int TIME_W      = 32;
    localparam int RATE_W      = 48;
    localparam int FRAC_W      = 16;
    localparam int STATUS_W    = 3;
    localparam int CFG_IDX_W   = 2;

    // Parameter defaults
    localparam int VALUE_BITS_DEF = 40;
    localparam int WRAP_BITS_DEF  = 32;

    // Rate range ends
    localparam logic signed [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
    localparam logic signed [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KIND       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RATE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE   = 2'd3;

    // Source kinds
    localparam logic [1:0] KIND_GAUGE    = 2'd0;
    localparam logic [1:0] KIND_COUNTER  = 2'd1;
    localparam logic [1:0] KIND_DERIVE   = 2'd2;
    localparam logic [1:0] KIND_ABSOLUTE = 2'd3;

    // Bound handling modes
    localparam logic [1:0] MODE_IGNORE  = 2'd0;
    localparam logic [1:0] MODE_DISCARD = 2'd1;
    localparam logic [1:0] MODE_CLAMP   = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_NORMAL  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_STALE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CLAMP   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DISCARD = 3'd4;

    // Divider status toward the sequencer
    typedef struct packed {
        logic done;
        logic ovf;
    } t_div_stat;

endpackage

// File: rtl/s2rc_div.sv
module s2rc_div #(
    parameter int DIVD_W = 67
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [DIVD_W-1:0]             i_dividend,
    input  logic [s2rc_pkg::TIME_W-1:0]   i_divisor,
    output logic [s2rc_pkg::RATE_W-1:0]   o_quot,
    output s2rc_pkg::t_div_stat           o_stat
);

    localparam int CNT_W = $clog2(DIVD_W + 1);
    localparam int DEN_W = s2rc_pkg::TIME_W;
    localparam int Q_W   = s2rc_pkg::RATE_W;

    logic [DIVD_W-1:0] r_dvd;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;
    logic [Q_W-1:0]    r_q;
    logic              r_ovf;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DEN_W:0]    rem_sh;
    logic [DEN_W:0]    rem_sub;
    logic              q_bit;

    // One restoring step: shift in the next dividend bit, try the subtract
    assign rem_sh  = {r_rem, r_dvd[DIVD_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign q_bit   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_dvd  <= i_dividend;
                r_den  <= i_divisor;
                r_rem  <= '0;
                r_q    <= '0;
                r_ovf  <= 1'b0;
                r_cnt  <= CNT_W'(DIVD_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_dvd <= r_dvd << 1;
                r_rem <= q_bit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                // remember any quotient bit pushed past the rate width
                r_ovf <= r_ovf | r_q[Q_W-1];
                r_q   <= {r_q[Q_W-2:0], q_bit};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot      = r_q;
    assign o_stat.done = r_done;
    assign o_stat.ovf  = r_ovf;

endmodule

// File: rtl/sample_to_rate_converter.sv
// Steps: a zero or stale sample, or a counter/derive with no previous reading, goes
// straight to the done state; gauge or a counter drop beyond the wrap range runs the
// difference, wrap, sign and bound states; a divided rate adds multiply, divider start
// and the divider, one quotient bit per cycle for DIVD_W = 67 bits. One request at a time;
// the next request is taken the cycle after the result enters the output register.
// Reset: synchronous active low; clears configuration, previous sample, control.
module sample_to_rate_converter #(
    parameter int VALUE_BITS = s2rc_pkg::VALUE_BITS_DEF,
    parameter int WRAP_BITS  = s2rc_pkg::WRAP_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // input channel
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic [s2rc_pkg::TIME_W-1:0]             i_sample_time,
    input  logic signed [VALUE_BITS-1:0]            i_sample_value,
    // output channel
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic signed [s2rc_pkg::RATE_W-1:0]      o_rate,
    output logic [s2rc_pkg::STATUS_W-1:0]           o_status,
    // configuration channel
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [s2rc_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [s2rc_pkg::RATE_W-1:0]             i_cfg_data
);

    localparam int RATE_W = s2rc_pkg::RATE_W;
    localparam int TIME_W = s2rc_pkg::TIME_W;
    localparam int FRAC_W = s2rc_pkg::FRAC_W;
    localparam int MAXB   = (VALUE_BITS > WRAP_BITS) ? VALUE_BITS : WRAP_BITS;
    localparam int DIFF_W = MAXB + 2;
    localparam int MAG_W  = DIFF_W - 1;
    localparam int NUM_W  = MAG_W + 10;
    localparam int DIVD_W = NUM_W + FRAC_W;
    localparam logic signed [DIFF_W-1:0] WRAP_ADD = DIFF_W'(1) << WRAP_BITS;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_WRAP,
        S_ABS,
        S_MUL,
        S_START,
        S_DIV,
        S_BOUND,
        S_DONE
    } t_state;

    t_state                          r_state;
    logic [1:0]                      r_kind;
    logic [1:0]                      r_mode;
    logic signed [RATE_W-1:0]        r_min;
    logic signed [RATE_W-1:0]        r_max;
    logic [TIME_W-1:0]               r_prev_time;
    logic signed [VALUE_BITS-1:0]    r_prev_val;
    logic signed [VALUE_BITS-1:0]    r_val;
    logic signed [VALUE_BITS-1:0]    r_old;
    logic [TIME_W-1:0]               r_dt;
    logic signed [DIFF_W-1:0]        r_diff;
    logic                            r_neg;
    logic [MAG_W-1:0]                r_mag;
    logic [NUM_W-1:0]                r_num;
    logic signed [RATE_W-1:0]        r_rate;
    logic [s2rc_pkg::STATUS_W-1:0]   r_status;
    logic                            r_out_valid;
    logic signed [RATE_W-1:0]        r_out_rate;
    logic [s2rc_pkg::STATUS_W-1:0]   r_out_status;

    logic                            in_acc;
    logic                            out_load;
    logic                            is_stale;
    logic                            no_prev;
    logic signed [63:0]              g_ext;
    logic signed [63:0]              g_wide;
    logic                            lo_hit;
    logic                            hi_hit;
    logic [RATE_W-1:0]               div_quot;
    s2rc_pkg::t_div_stat             div_stat;

    // Bit-serial divider
    s2rc_div #(
        .DIVD_W (DIVD_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_START),
        .i_dividend ({r_num, {FRAC_W{1'b0}}}),
        .i_divisor  (r_dt),
        .o_quot     (div_quot),
        .o_stat     (div_stat)
    );

    // Handshake terms
    assign o_stall     = (r_state != S_IDLE);
    assign in_acc      = i_valid && (r_state == S_IDLE);
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || !i_stall);
    assign o_cfg_ready = 1'b1;

    // Sample classification at accept
    assign is_stale = (r_kind != s2rc_pkg::KIND_GAUGE) && (r_prev_time >= i_sample_time);
    assign no_prev  = ((r_kind == s2rc_pkg::KIND_COUNTER) || (r_kind == s2rc_pkg::KIND_DERIVE))
                      && (r_prev_val == '0);

    // Gauge scaling
    assign g_ext  = 64'(r_diff);
    assign g_wide = g_ext <<< FRAC_W;

    // Bound checks
    assign lo_hit = (r_min != '0) && (r_rate < r_min);
    assign hi_hit = (r_max != '0) && (r_rate > r_max);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= s2rc_pkg::KIND_GAUGE;
            r_mode      <= s2rc_pkg::MODE_IGNORE;
            r_min       <= '0;
            r_max       <= '0;
            r_prev_time <= '0;
            r_prev_val  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // take configuration writes
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    s2rc_pkg::CFG_KIND:       r_kind <= i_cfg_data[1:0];
                    s2rc_pkg::CFG_RANGE_MODE: r_mode <= i_cfg_data[1:0];
                    s2rc_pkg::CFG_MIN_RATE:   r_min  <= i_cfg_data;
                    s2rc_pkg::CFG_MAX_RATE:   r_max  <= i_cfg_data;
                    default: ;
                endcase
            end

            // drain or load the output register
            if (out_load) begin
                r_out_valid  <= 1'b1;
                r_out_rate   <= r_rate;
                r_out_status <= r_status;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_rate   <= '0;
                        r_val    <= i_sample_value;
                        r_old    <= r_prev_val;
                        r_dt     <= i_sample_time - r_prev_time;
                        if (i_sample_value == '0) begin
                            r_status <= s2rc_pkg::ST_ZERO;
                            r_state  <= S_DONE;
                        end else if (is_stale) begin
                            r_status <= s2rc_pkg::ST_STALE;
                            r_state  <= S_DONE;
                        end else begin
                            r_status    <= s2rc_pkg::ST_NORMAL;
                            r_prev_time <= i_sample_time;
                            r_prev_val  <= i_sample_value;
                            r_state     <= no_prev ? S_DONE : S_DIFF;
                        end
                    end
                end
                S_DIFF: begin
                    if ((r_kind == s2rc_pkg::KIND_COUNTER) ||
                        (r_kind == s2rc_pkg::KIND_DERIVE)) begin
                        r_diff <= DIFF_W'(r_val) - DIFF_W'(r_old);
                    end else begin
                        r_diff <= DIFF_W'(r_val);
                    end
                    r_state <= S_WRAP;
                end
                S_WRAP: begin
                    // counter rollover
                    if ((r_kind == s2rc_pkg::KIND_COUNTER) && (r_diff < 0)) begin
                        r_diff <= r_diff + WRAP_ADD;
                    end
                    r_state <= S_ABS;
                end
                S_ABS: begin
                    r_neg <= r_diff < 0;
                    r_mag <= (r_diff < 0) ? MAG_W'(-r_diff) : MAG_W'(r_diff);
                    if (r_kind == s2rc_pkg::KIND_GAUGE) begin
                        if (g_ext >= 64'sd2147483648) begin
                            r_rate <= s2rc_pkg::RATE_MAX;
                        end else if (g_ext <= -64'sd2147483648) begin
                            r_rate <= s2rc_pkg::RATE_MIN;
                        end else begin
                            r_rate <= g_wide[RATE_W-1:0];
                        end
                        r_state <= S_BOUND;
                    end else if ((r_kind == s2rc_pkg::KIND_COUNTER) && (r_diff < 0)) begin
                        // drop beyond the wrap range
                        r_rate  <= s2rc_pkg::RATE_MAX;
                        r_state <= S_BOUND;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    // times 1000 as 1024 - 32 + 8
                    r_num   <= (NUM_W'(r_mag) << 10) - (NUM_W'(r_mag) << 5)
                               + (NUM_W'(r_mag) << 3);
                    r_state <= S_START;
                end
                S_START: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        if (r_neg) begin
                            if (div_stat.ovf ||
                                (div_quot[RATE_W-1] && (div_quot[RATE_W-2:0] != '0))) begin
                                r_rate <= s2rc_pkg::RATE_MIN;
                            end else begin
                                r_rate <= -$signed(div_quot);
                            end
                        end else begin
                            if (div_stat.ovf || div_quot[RATE_W-1]) begin
                                r_rate <= s2rc_pkg::RATE_MAX;
                            end else begin
                                r_rate <= $signed(div_quot);
                            end
                        end
                        r_state <= S_BOUND;
                    end
                end
                S_BOUND: begin
                    if ((r_rate != '0) && (r_mode != s2rc_pkg::MODE_IGNORE)) begin
                        if (lo_hit) begin
                            if (r_mode == s2rc_pkg::MODE_CLAMP) begin
                                r_rate   <= r_min;
                                r_status <= s2rc_pkg::ST_CLAMP;
                            end else begin
                                r_rate   <= '0;
                                r_status <= s2rc_pkg::ST_DISCARD;
                            end
                        end else if (hi_hit) begin
                            if (r_mode == s2rc_pkg::MODE_CLAMP) begin
                                r_rate   <= r_max;
                                r_status <= s2rc_pkg::ST_CLAMP;
                            end else begin
                                r_rate   <= '0;
                                r_status <= s2rc_pkg::ST_DISCARD;
                            end
                        end
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid  = r_out_valid;
    assign o_rate   = r_out_rate;
    assign o_status = r_out_status;

endmodule

// File: tb/sv/s2rc_rate_checker.sv
// Watches the sample, result and register channels of the rate converter,
// predicts every result and compares it with what the block delivers.
module s2rc_rate_checker (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    // sample channel
    input  logic                                        i_in_valid,
    input  logic                                        i_in_stall,
    input  logic [s2rc_pkg::TIME_W-1:0]                 i_in_time,
    input  logic signed [s2rc_pkg::VALUE_BITS_DEF-1:0]  i_in_value,
    // result channel
    input  logic                                        i_out_valid,
    input  logic                                        i_out_stall,
    input  logic signed [s2rc_pkg::RATE_W-1:0]          i_out_rate,
    input  logic [s2rc_pkg::STATUS_W-1:0]               i_out_status,
    // register channel
    input  logic                                        i_cfg_valid,
    input  logic                                        i_cfg_ready,
    input  logic [s2rc_pkg::CFG_IDX_W-1:0]              i_cfg_index,
    input  logic [s2rc_pkg::RATE_W-1:0]                 i_cfg_data,
    // tallies toward the testbench top
    output int                                          o_pending,
    output int                                          o_errors,
    output int                                          o_results,
    output int                                          o_bounded,
    output int                                          o_saturated,
    output int                                          o_skipped
);
    import s2rc_pkg::*;

    localparam int VB = VALUE_BITS_DEF;
    localparam logic signed [63:0] WRAP_SPAN = 64'sd1 << WRAP_BITS_DEF;
    localparam logic [63:0] MS_PER_SEC = 64'd1000;
    localparam logic [63:0] MS_Q16 = MS_PER_SEC << FRAC_W;

    typedef struct packed {
        logic [RATE_W-1:0]   rate;
        logic [STATUS_W-1:0] status;
    } rate_result_t;

    // Shadow of the block's registers and of its last stored sample
    logic [1:0]                cfg_kind;
    logic [1:0]                cfg_mode;
    logic signed [RATE_W-1:0]  cfg_min;
    logic signed [RATE_W-1:0]  cfg_max;
    logic [TIME_W-1:0]         last_time;
    logic signed [VB-1:0]      last_value;

    rate_result_t rates_due[$];
    int errors;
    int results;
    int bounded;
    int saturated;
    int skipped;

    // Force a sign and magnitude into the signed rate range
    function automatic logic signed [RATE_W-1:0] saturate_rate(input logic neg,
                                                               input logic [63:0] mag);
        logic [63:0] cap;
        cap = neg ? (64'd1 << (RATE_W - 1)) : ((64'd1 << (RATE_W - 1)) - 64'd1);
        if (mag > cap)
            mag = cap;
        return neg ? -mag[RATE_W-1:0] : mag[RATE_W-1:0];
    endfunction

    // Q32.16 of num per dt milliseconds, in units per second, toward zero
    function automatic logic signed [RATE_W-1:0] per_second(input logic signed [63:0] num,
                                                            input logic [TIME_W-1:0] dt);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] quot;
        logic [63:0] rem;
        neg  = num < 0;
        mag  = neg ? 64'(-num) : 64'(num);
        quot = mag / 64'(dt);
        rem  = mag % 64'(dt);
        // a whole quotient this large is beyond the range once scaled
        if (quot >= (64'd1 << 22))
            return saturate_rate(neg, 64'd1 << RATE_W);
        return saturate_rate(neg, quot * MS_Q16 + (rem * MS_Q16) / 64'(dt));
    endfunction

    // Work out the result of one sample and advance the stored sample
    function automatic rate_result_t predict_rate(input logic [TIME_W-1:0] t,
                                                  input logic signed [VB-1:0] v);
        rate_result_t             res;
        logic signed [RATE_W-1:0] r;
        logic [STATUS_W-1:0]      st;
        logic signed [63:0]       cur;
        logic signed [63:0]       old;
        logic signed [63:0]       diff;
        logic [63:0]              mag;
        logic [TIME_W-1:0]        dt;
        r   = '0;
        st  = ST_NORMAL;
        cur = v;
        old = last_value;
        if (v == 0) begin
            st = ST_ZERO;
        end else if (cfg_kind != KIND_GAUGE && last_time >= t) begin
            st = ST_STALE;
        end else begin
            dt = t - last_time;
            case (cfg_kind)
                KIND_GAUGE: begin
                    mag = (cur < 0) ? 64'(-cur) : 64'(cur);
                    if (mag >= (64'd1 << 31))
                        r = saturate_rate(cur < 0, 64'd1 << RATE_W);
                    else
                        r = saturate_rate(cur < 0, mag << FRAC_W);
                end
                KIND_COUNTER: begin
                    if (old != 0) begin
                        diff = cur - old;
                        if (diff < 0)
                            diff = diff + WRAP_SPAN;
                        r = (diff < 0) ? RATE_MAX : per_second(diff, dt);
                    end
                end
                KIND_DERIVE: begin
                    if (old != 0)
                        r = per_second(cur - old, dt);
                end
                default: begin
                    r = per_second(cur, dt);
                end
            endcase
            // apply the bounds, lower one first; the spare mode discards
            if (r != 0 && cfg_mode != MODE_IGNORE) begin
                if (cfg_min != 0 && r < cfg_min) begin
                    st = (cfg_mode == MODE_CLAMP) ? ST_CLAMP : ST_DISCARD;
                    r  = (cfg_mode == MODE_CLAMP) ? cfg_min : '0;
                end else if (cfg_max != 0 && r > cfg_max) begin
                    st = (cfg_mode == MODE_CLAMP) ? ST_CLAMP : ST_DISCARD;
                    r  = (cfg_mode == MODE_CLAMP) ? cfg_max : '0;
                end
            end
            last_time  = t;
            last_value = v;
        end
        res.rate   = r;
        res.status = st;
        return res;
    endfunction

    // Track registers, check results, queue predictions
    always @(posedge i_clk) begin : watch
        rate_result_t want;
        if (!i_rst_n) begin
            cfg_kind   = KIND_GAUGE;
            cfg_mode   = MODE_IGNORE;
            cfg_min    = '0;
            cfg_max    = '0;
            last_time  = '0;
            last_value = '0;
            rates_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                results++;
                if (i_out_status == ST_CLAMP || i_out_status == ST_DISCARD)
                    bounded++;
                if (i_out_status == ST_ZERO || i_out_status == ST_STALE)
                    skipped++;
                if (i_out_rate == RATE_MAX || i_out_rate == RATE_MIN)
                    saturated++;
                if (rates_due.size() == 0) begin
                    $error("result with no request waiting: rate %0d status %0d",
                           i_out_rate, i_out_status);
                    errors++;
                end else begin
                    want = rates_due.pop_front();
                    if (i_out_rate !== want.rate) begin
                        $error("rate: expected %0d, got %0d", $signed(want.rate), i_out_rate);
                        errors++;
                    end
                    if (i_out_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_out_status);
                        errors++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                rates_due.push_back(predict_rate(i_in_time, i_in_value));
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_KIND:       cfg_kind = i_cfg_data[1:0];
                    CFG_RANGE_MODE: cfg_mode = i_cfg_data[1:0];
                    CFG_MIN_RATE:   cfg_min  = i_cfg_data;
                    default:        cfg_max  = i_cfg_data;
                endcase
            end
        end
        o_pending   <= rates_due.size();
        o_errors    <= errors;
        o_results   <= results;
        o_bounded   <= bounded;
        o_saturated <= saturated;
        o_skipped   <= skipped;
    end

endmodule

// File: tb/sv/sample_to_rate_converter_tb.sv
module sample_to_rate_converter_tb;
    import s2rc_pkg::*;

    localparam int VB           = VALUE_BITS_DEF;
    localparam int RESET_CYCLES = 6;
    localparam int SAMPLE_COUNT = 700;
    localparam int CALM_FROM    = 600;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 100;

    localparam logic [1:0]           MODE_SPARE = 2'd3;
    localparam logic signed [VB-1:0] VALUE_MAX  = {1'b0, {(VB-1){1'b1}}};
    localparam logic signed [VB-1:0] VALUE_MIN  = {1'b1, {(VB-1){1'b0}}};

    logic                       i_clk          = 1'b0;
    logic                       i_rst_n        = 1'b0;
    logic                       i_valid        = 1'b0;
    logic                       o_stall;
    logic [TIME_W-1:0]          i_sample_time  = '0;
    logic signed [VB-1:0]       i_sample_value = '0;
    logic                       o_valid;
    logic                       i_stall        = 1'b0;
    logic signed [RATE_W-1:0]   o_rate;
    logic [STATUS_W-1:0]        o_status;
    logic                       i_cfg_valid    = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index    = '0;
    logic [RATE_W-1:0]          i_cfg_data     = '0;

    int results_due;
    int check_errors;
    int results_seen;
    int bounded_seen;
    int saturated_seen;
    int skipped_seen;

    // Stimulus state
    int                   samples_sent = 0;
    int                   settings_used = 0;
    int                   tx_idle_pct = 0;
    int                   rx_idle_pct = 0;
    bit                   long_hold_req = 1'b0;
    int                   quiet_cycles = 0;
    logic [1:0]           cur_kind = KIND_GAUGE;
    logic [TIME_W-1:0]    t_hi = '0;
    logic signed [VB-1:0] v_prev = '0;

    sample_to_rate_converter i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample_time  (i_sample_time),
        .i_sample_value (i_sample_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_rate         (o_rate),
        .o_status       (o_status),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    s2rc_rate_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_time    (i_sample_time),
        .i_in_value   (i_sample_value),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_rate   (o_rate),
        .i_out_status (o_status),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (results_due),
        .o_errors     (check_errors),
        .o_results    (results_seen),
        .o_bounded    (bounded_seen),
        .o_saturated  (saturated_seen),
        .o_skipped    (skipped_seen)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Count cycles in which no channel moves anything
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge i_clk);
        $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // Stall the result side: a long hold-off on request, else random bursts
    always begin
        @(posedge i_clk);
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            i_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            i_stall <= 1'b0;
        end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
            i_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
            i_stall <= 1'b0;
        end
    end

    function automatic logic [RATE_W-1:0] q16(input int units);
        return RATE_W'(units) << FRAC_W;
    endfunction

    // Signed value of random magnitude
    function automatic logic signed [VB-1:0] wide_value();
        logic [63:0]          raw;
        logic signed [VB-1:0] mag;
        raw = {$urandom, $urandom} >> $urandom_range(24, 63);
        mag = raw[VB-1:0];
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    // Rate bound: often off, sometimes an end of the range or plus or minus one, else random
    function automatic logic [RATE_W-1:0] rand_bound();
        logic [63:0] mag;
        mag = {$urandom, $urandom} >> $urandom_range(17, 50);
        case ($urandom_range(0, 9))
            0, 1, 2: return '0;
            3:       return RATE_MAX;
            4:       return RATE_MIN;
            5:       return RATE_W'(1);
            6:       return '1;
            default: return $urandom_range(0, 1) ? -mag[RATE_W-1:0] : mag[RATE_W-1:0];
        endcase
    endfunction

    // Drop the request and wait until every result has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (results_due != 0)
            @(posedge i_clk);
    endtask

    // Write all four registers once the block is idle
    task automatic load_config(input logic [1:0] kind, input logic [1:0] mode,
                               input logic [RATE_W-1:0] lo, input logic [RATE_W-1:0] hi);
        logic [CFG_IDX_W-1:0] reg_idx [4];
        logic [RATE_W-1:0]    reg_val [4];
        reg_idx = '{CFG_KIND, CFG_RANGE_MODE, CFG_MIN_RATE, CFG_MAX_RATE};
        reg_val = '{RATE_W'(kind), RATE_W'(mode), lo, hi};
        drain_results();
        for (int r = 0; r < 4; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= reg_idx[r];
            i_cfg_data  <= reg_val[r];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        cur_kind = kind;
        settings_used++;
    endtask

    // Offer one sample, with an optional gap in front, and hold it until taken
    task automatic send_sample(input logic [TIME_W-1:0] t, input logic signed [VB-1:0] v);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_sample_time  <= t;
        i_sample_value <= v;
        do @(posedge i_clk); while (o_stall);
        samples_sent++;
        // t_hi never falls below the time the block holds
        if (v != 0 && (cur_kind == KIND_GAUGE || t > t_hi)) begin
            t_hi   = t;
            v_prev = v;
        end
    endtask

    // Mostly a plausible next sample for the current kind, some noise
    task automatic make_sample(output logic [TIME_W-1:0] t, output logic signed [VB-1:0] v);
        int                pick;
        int                step;
        logic [TIME_W-1:0] dt;
        logic [31:0]       count;
        logic [31:0]       delta;
        pick = $urandom_range(0, 99);
        step = $urandom_range(0, 9);
        if (step < 7)
            dt = $urandom_range(1, 2000);
        else if (step < 9)
            dt = $urandom_range(1, 32'h10_0000);
        else
            dt = $urandom_range(1, ~t_hi);
        t = t_hi + dt;
        v = wide_value();
        if (pick < 4) begin
            v = '0;
        end else if (pick < 8) begin
            t = t_hi - $urandom_range(0, 50);
        end else if (pick < 14) begin
            t = $urandom;
            v = VB'({$urandom, $urandom});
        end else if (pick < 18) begin
            case ($urandom_range(0, 3))
                0:       v = VALUE_MAX;
                1:       v = VALUE_MIN;
                2:       v = 1;
                default: v = -1;
            endcase
        end else begin
            case (cur_kind)
                KIND_GAUGE: begin
                    t = $urandom_range(0, 32'hF_FFFF);
                end
                KIND_COUNTER: begin
                    // jump near the top now and then so the reading wraps
                    if ($urandom_range(0, 19) == 0)
                        count = $urandom | 32'hFFFF_0000;
                    else
                        count = v_prev[31:0] + $urandom_range(0, 1 << $urandom_range(0, 24));
                    v = VB'(count);
                end
                KIND_DERIVE: begin
                    delta = $urandom >> $urandom_range(0, 31);
                    v = $urandom_range(0, 1) ? v_prev - VB'(delta) : v_prev + VB'(delta);
                end
                default: begin
                end
            endcase
        end
    endtask

    initial begin
        int                   n;
        int                   phase;
        int                   m;
        logic [1:0]           kind_pick;
        logic [1:0]           mode_pick;
        logic [TIME_W-1:0]    t;
        logic signed [VB-1:0] v;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tx_idle_pct = 20;
        rx_idle_pct = 20;

        // Counter right after reset: no previous reading, then steps, stale and zero samples, wraps
        load_config(KIND_COUNTER, MODE_IGNORE, '0, '0);
        send_sample(32'd1000, 40'sd500);
        send_sample(32'd2000, 40'sd1500);
        send_sample(32'd2000, 40'sd1600);
        send_sample(32'd1500, 40'sd1600);
        send_sample(32'd2500, 40'sd0);
        send_sample(32'd3000, 40'sd4294967290);
        send_sample(32'd3003, 40'sd10);
        send_sample(32'd3004, VALUE_MIN);
        send_sample(32'd3005, VALUE_MAX);

        // Derive: saturate low, exact step, saturate high
        load_config(KIND_DERIVE, MODE_IGNORE, '0, '0);
        send_sample(32'd4005, VALUE_MIN);
        send_sample(32'd4012, VALUE_MIN + 7);
        send_sample(32'd4015, VALUE_MIN - 3);

        // Absolute: stale, longest interval, stale at time zero
        load_config(KIND_ABSOLUTE, MODE_IGNORE, q16(100), q16(200));
        send_sample(32'd4015, 40'sd5);
        send_sample(32'hFFFF_FFFF, 40'sd3);
        send_sample(32'd0, 40'sd9);

        // Gauge: range edges, time going back
        load_config(KIND_GAUGE, MODE_IGNORE, '0, '0);
        send_sample(32'd0, 40'sd2147483647);
        send_sample(32'd5, 40'sd2147483648);
        send_sample(32'd6, -40'sd2147483648);
        send_sample(32'd7, -40'sd2147483647);

        // Bounds: clamp both ways, discard with lower bound tested first
        load_config(KIND_ABSOLUTE, MODE_CLAMP, q16(100), q16(2000));
        send_sample(32'd1007, 40'sd50);
        send_sample(32'd2007, 40'sd5000);
        send_sample(32'd3007, 40'sd500);
        load_config(KIND_ABSOLUTE, MODE_DISCARD, q16(3000), q16(1000));
        send_sample(32'd4007, 40'sd500);
        send_sample(32'd5007, -40'sd7);
        load_config(KIND_ABSOLUTE, MODE_SPARE, '0, q16(100));
        send_sample(32'd6007, 40'sd200);

        // Random settings, each followed by a run of samples
        phase = 0;
        while (samples_sent < SAMPLE_COUNT) begin
            kind_pick = $urandom_range(0, 3);
            // fall back to gauge to bring the time down again
            if (t_hi > 32'hC000_0000)
                kind_pick = KIND_GAUGE;
            m = $urandom_range(0, 9);
            mode_pick = (m < 2) ? MODE_IGNORE : (m < 5) ? MODE_DISCARD :
                        (m < 9) ? MODE_CLAMP : MODE_SPARE;
            load_config(kind_pick, mode_pick, rand_bound(), rand_bound());
            if (samples_sent >= CALM_FROM) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else begin
                case ($urandom_range(0, 3))
                    0:       tx_idle_pct = 0;
                    1:       tx_idle_pct = 10;
                    2:       tx_idle_pct = 30;
                    default: tx_idle_pct = 60;
                endcase
                case ($urandom_range(0, 3))
                    0:       rx_idle_pct = 0;
                    1:       rx_idle_pct = 5;
                    2:       rx_idle_pct = 20;
                    default: rx_idle_pct = 50;
                endcase
            end
            // hold off the result side while samples keep coming
            if (phase == 6)
                long_hold_req = 1'b1;
            n = $urandom_range(8, 40);
            for (int i = 0; i < n; i++) begin
                if (phase == 10 && i == n / 2)
                    drain_results();
                make_sample(t, v);
                send_sample(t, v);
            end
            phase++;
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("sent %0d samples under %0d register settings, all kinds and bound modes",
                 samples_sent, settings_used);
        $display("results %0d: %0d bounded, %0d saturated, %0d zero or stale",
                 results_seen, bounded_seen, saturated_seen, skipped_seen);
        if (check_errors == 0 && results_due == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
